[rtl/core/pfp_pkg.sv]
`timescale 1ns / 1ps

package pfp_pkg;

    // Fixed field widths
    localparam int COORD_BITS    = 16;
    localparam int CFG_W         = 12;
    localparam int BALL_W        = 12;
    localparam int DELAY_W       = 9;
    localparam int FRACTION_BITS_DEF = 16;

    // Register reset values
    localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd150;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd100;

    // Register indexes on the configuration port
    typedef enum logic {
        REG_WINDOW_WIDTH  = 1'b0,
        REG_WINDOW_HEIGHT = 1'b1
    } pfp_reg_t;

    // Geometry: signed width that holds every eye size and centre
    localparam int GEO_W = 14;

    // Exact reciprocals for 12-bit dividends: floor(x * R >> 16) == x / d
    localparam int RECIP_SHIFT = 16;
    localparam logic [12:0] RECIP15 = 13'd4370;
    localparam logic [12:0] RECIP20 = 13'd3277;
    localparam logic [13:0] RECIP5  = 14'd13108;

    // At or beyond a magnitude of 2**FAR_SHIFT the pointer is far and the deltas are halved
    localparam int FAR_SHIFT = 17;
    localparam int NEAR_W    = 17;
    localparam int SQRT_STEPS = 31;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] pointer_x;
        logic signed [COORD_BITS-1:0] pointer_y;
    } pfp_in_t;

    typedef struct packed {
        logic                         moved;
        logic signed [COORD_BITS-1:0] left_pupil_x;
        logic signed [COORD_BITS-1:0] left_pupil_y;
        logic signed [COORD_BITS-1:0] right_pupil_x;
        logic signed [COORD_BITS-1:0] right_pupil_y;
        logic [BALL_W-1:0]            ball_size;
        logic [DELAY_W-1:0]           next_delay_ms;
    } pfp_out_t;

    typedef struct packed {
        logic capture;
        logic geo0;
        logic geo1;
        logic geo2;
        logic geo3;
        logic eye_load;
        logic far_step;
        logic mul1;
        logic mul2;
        logic sum;
        logic store_ptr;
        logic store_ctr;
        logic norm_step;
        logic sqrt_load;
        logic sqrt_step;
        logic div_load;
        logic div_step;
        logic store_off;
        logic out_load;
        logic eye;
    } pfp_cmd_t;

    typedef struct packed {
        logic far;
        logic hit;
        logic degenerate;
        logic norm_more;
    } pfp_sts_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_GEO0,
        ST_GEO1,
        ST_GEO2,
        ST_GEO3,
        ST_EYE,
        ST_FAR,
        ST_MUL1,
        ST_MUL2,
        ST_SUM,
        ST_DECIDE,
        ST_NORM,
        ST_SQRT,
        ST_DIVLOAD,
        ST_DIV,
        ST_OFF,
        ST_OUT
    } pfp_state_t;

    // Poll backoff in milliseconds
    function automatic logic [DELAY_W-1:0] delay_ms(input logic [1:0] idx);
        logic [DELAY_W-1:0] d;
        unique case (idx)
            2'd0:    d = 9'd50;
            2'd1:    d = 9'd100;
            2'd2:    d = 9'd200;
            default: d = 9'd400;
        endcase
        return d;
    endfunction

    // Halve, rounding toward zero
    function automatic logic signed [GEO_W-1:0] half_tz(input logic signed [GEO_W-1:0] v);
        logic signed [GEO_W-1:0] t;
        t = v + $signed({{(GEO_W-1){1'b0}}, v[GEO_W-1]});
        return t >>> 1;
    endfunction

endpackage

[rtl/core/pupil_follow_pointer_unit.sv]
`timescale 1ns / 1ps

// Pupil placement for a pair of eyes that follow a polled pointer.
// Input channel (in_valid/in_ready/in_data): one beat per poll, the pointer
// position relative to the window origin. Output channel (out_valid/
// out_ready/out_data): one beat per poll with the moved flag, both pupil
// centres, the pupil size and the delay until the next poll.
// Configuration: write window_width (index 0) or window_height (index 1)
// with cfg_write high for one cycle, only while no poll is in flight.
// A poll whose pupils both sit at the pointer skips the root and divide;
// a pupil clamped to the ellipse runs the normalize loop, the 31-step
// square root and the FRACTION_BITS+13-step divider, all on one shared
// datapath. One poll is worked at a time. Far pointers first have their
// deltas halved, one halving per step, until they are near.
// The result sits in an output register: a new poll is taken while it
// waits, and the finished poll holds in the controller until the receiver
// frees the register. Reset restores the 150x100 window, clears the stored
// pointer and the backoff, and drops any beat in flight.
module pupil_follow_pointer_unit
    import pfp_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             in_valid,
    output logic             in_ready,
    input  pfp_in_t          in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output pfp_out_t         out_data
);

    pfp_cmd_t cmd;
    pfp_sts_t sts;

    // Sequencer: geometry, then per eye the half-ellipse test and, if clamped, root and divide
    pfp_ctrl #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Window registers, poll state and the shared arithmetic
    pfp_datapath #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_data  (out_data)
    );

endmodule

[rtl/core/pfp_ctrl.sv]
`timescale 1ns / 1ps

module pfp_ctrl
    import pfp_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  pfp_sts_t sts,
    output pfp_cmd_t cmd
);

    localparam int DIV_STEPS = FRACTION_BITS + 13;
    localparam int MAX_STEPS = (DIV_STEPS > SQRT_STEPS) ? DIV_STEPS : SQRT_STEPS;
    localparam int CNT_W     = $clog2(MAX_STEPS);

    pfp_state_t       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             eye_reg, eye_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            eye_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            eye_reg       <= eye_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        eye_next       = eye_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:    if (in_valid) state_next = ST_GEO0;
            ST_GEO0:    state_next = ST_GEO1;
            ST_GEO1:    state_next = ST_GEO2;
            ST_GEO2:    state_next = ST_GEO3;
            ST_GEO3:
            begin
                state_next = ST_EYE;
                eye_next   = 1'b0;
            end
            ST_EYE:     state_next = ST_FAR;
            ST_FAR:     if (!sts.far) state_next = ST_MUL1;
            ST_MUL1:    state_next = ST_MUL2;
            ST_MUL2:    state_next = ST_SUM;
            ST_SUM:     state_next = ST_DECIDE;
            ST_DECIDE:
            begin
                if (sts.hit || sts.degenerate)
                begin
                    state_next = eye_reg ? ST_OUT : ST_EYE;
                    eye_next   = 1'b1;
                end
                else
                begin
                    state_next = ST_NORM;
                end
            end
            ST_NORM:
            begin
                if (!sts.norm_more)
                begin
                    state_next = ST_SQRT;
                    cnt_next   = '0;
                end
            end
            ST_SQRT:
            begin
                if (cnt_reg == CNT_W'(SQRT_STEPS - 1))
                    state_next = ST_DIVLOAD;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_DIVLOAD:
            begin
                state_next = ST_DIV;
                cnt_next   = '0;
            end
            ST_DIV:
            begin
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                    state_next = ST_OFF;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_OFF:
            begin
                state_next = eye_reg ? ST_OUT : ST_EYE;
                eye_next   = 1'b1;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // Commands
    always_comb
    begin
        cmd     = '0;
        cmd.eye = eye_reg;
        unique case (state_reg)
            ST_IDLE:    cmd.capture   = in_valid;
            ST_GEO0:    cmd.geo0      = 1'b1;
            ST_GEO1:    cmd.geo1      = 1'b1;
            ST_GEO2:    cmd.geo2      = 1'b1;
            ST_GEO3:    cmd.geo3      = 1'b1;
            ST_EYE:     cmd.eye_load  = 1'b1;
            ST_FAR:     cmd.far_step  = sts.far;
            ST_MUL1:    cmd.mul1      = 1'b1;
            ST_MUL2:    cmd.mul2      = 1'b1;
            ST_SUM:     cmd.sum       = 1'b1;
            ST_DECIDE:
            begin
                cmd.store_ptr = sts.hit;
                cmd.store_ctr = !sts.hit && sts.degenerate;
            end
            ST_NORM:
            begin
                cmd.norm_step = sts.norm_more;
                cmd.sqrt_load = !sts.norm_more;
            end
            ST_SQRT:    cmd.sqrt_step = 1'b1;
            ST_DIVLOAD: cmd.div_load  = 1'b1;
            ST_DIV:     cmd.div_step  = 1'b1;
            ST_OFF:     cmd.store_off = 1'b1;
            ST_OUT:     cmd.out_load  = out_free;
            default:    cmd = '0;
        endcase
    end

endmodule

[rtl/core/pfp_datapath.sv]
`timescale 1ns / 1ps

module pfp_datapath
    import pfp_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  pfp_in_t          in_data,
    input  pfp_cmd_t         cmd,
    output pfp_sts_t         sts,
    output pfp_out_t         out_data
);

    localparam int FB     = FRACTION_BITS;
    localparam int DW     = COORD_BITS + 3;
    localparam int CMPW   = (DW > FAR_SHIFT + 1) ? DW : FAR_SHIFT + 1;
    localparam int HW     = 12 + NEAR_W;
    localparam int SQW    = 2 * HW;
    localparam int QW     = SQW + 1;
    localparam int NX_W   = 62;
    localparam int NUM_W  = 24 + NEAR_W;
    localparam int K      = FB + 13;
    localparam int NW     = NUM_W + 2 * FB;
    localparam int EW     = $clog2(FB + 1);
    localparam int SHW    = $clog2(2 * FB + 1);
    localparam int RM_W   = 35;
    localparam int DEN_W  = 34;
    localparam int TW     = FB + 17;
    localparam int BIAS_I = (1 << FB) - 1;

    // Configuration and poll state
    logic [CFG_W-1:0] width_reg, height_reg;
    logic [COORD_BITS-1:0] last_x_reg, last_y_reg;
    logic [1:0] backoff_reg;

    // Item registers
    logic signed [COORD_BITS-1:0] px_reg, py_reg;
    logic moved_reg;
    logic [8:0] thick_reg, w20_reg, h20_reg, padx_reg, pady_reg;
    logic signed [GEO_W-1:0] ew_reg, eh_reg, cx0_reg, cx1_reg, cy_reg, cx_reg;
    logic [BALL_W-1:0] ball_reg;
    logic [11:0] aw_reg, ah_reg;
    logic [23:0] p_reg;
    logic negx_reg, negy_reg, far_seen_reg;
    logic [DW-1:0] adx_reg, ady_reg;
    logic [HW-1:0] hx_reg, hy_reg;
    logic [NUM_W-1:0] numx_reg, numy_reg;
    logic [SQW-1:0] sqx_reg, sqy_reg;
    logic [47:0] pp_reg;
    logic [QW-1:0] q_reg;
    logic [NX_W-1:0] nx_reg, src_reg;
    logic [EW-1:0] e_reg;
    logic [RM_W-1:0] rm_reg;
    logic [31:0] rt_reg;
    logic [DEN_W-1:0] den_reg, remx_reg, remy_reg;
    logic [K-1:0] dvdx_reg, dvdy_reg, qx_reg, qy_reg;
    logic signed [COORD_BITS-1:0] lx_reg, ly_reg, rx_reg, ry_reg;
    pfp_out_t out_reg;

    // Combinational helpers
    logic [12:0] wh_sum;
    logic [24:0] t15, t20w, t20h, t5;
    logic signed [GEO_W-1:0] sw, sh, spadx, spady, diff, ew_c, eh_c, s2;
    logic signed [GEO_W-1:0] cx0_c, cx_sel;
    logic signed [DW-1:0] dx, dy;
    logic [DW-1:0] adx_c, ady_c;
    logic far_c, far_now;
    logic [NEAR_W-1:0] adn, ady_n;
    logic [RM_W-1:0] sq_t, sq_trial;
    logic [SHW-1:0] sh_amt;
    logic [NW-1:0] shx, shy;
    logic [DEN_W-1:0] dtx, dty;
    logic signed [TW-1:0] cxs, cys, offx, offy, totx, toty, resx, resy;
    logic moved_c;

    assign wh_sum = {1'b0, width_reg} + {1'b0, height_reg};
    assign t15    = 25'(wh_sum[12:1]) * 25'(RECIP15);
    assign t20w   = 25'(width_reg) * 25'(RECIP20);
    assign t20h   = 25'(height_reg) * 25'(RECIP20);

    assign sw    = $signed(GEO_W'(width_reg));
    assign sh    = $signed(GEO_W'(height_reg));
    assign spadx = $signed(GEO_W'(padx_reg));
    assign spady = $signed(GEO_W'(pady_reg));
    assign diff  = sw - spadx;
    assign ew_c  = half_tz(diff) - spadx;
    assign eh_c  = sh - (spady <<< 1);
    assign s2    = half_tz(ew_reg + eh_reg);
    assign t5    = 25'(s2[11:0]) * 25'(RECIP5);
    assign cx0_c = spadx + half_tz(ew_reg);

    assign cx_sel = cmd.eye ? cx1_reg : cx0_reg;
    assign dx     = DW'(px_reg) - DW'(cx_sel);
    assign dy     = DW'(py_reg) - DW'(cy_reg);
    assign adx_c  = dx[DW-1] ? DW'(-dx) : DW'(dx);
    assign ady_c  = dy[DW-1] ? DW'(-dy) : DW'(dy);
    assign far_c  = (CMPW'(adx_c) >= (CMPW'(1) << FAR_SHIFT))
                 || (CMPW'(ady_c) >= (CMPW'(1) << FAR_SHIFT));
    assign far_now = (CMPW'(adx_reg) >= (CMPW'(1) << FAR_SHIFT))
                  || (CMPW'(ady_reg) >= (CMPW'(1) << FAR_SHIFT));
    assign adn    = NEAR_W'(adx_reg);
    assign ady_n  = NEAR_W'(ady_reg);

    assign sq_t     = {rm_reg[RM_W-3:0], src_reg[NX_W-1:NX_W-2]};
    assign sq_trial = {1'b0, rt_reg, 2'b01};

    assign sh_amt = SHW'(e_reg) + SHW'(FB);
    assign shx    = NW'(numx_reg) << sh_amt;
    assign shy    = NW'(numy_reg) << sh_amt;
    assign dtx    = {remx_reg[DEN_W-2:0], dvdx_reg[K-1]};
    assign dty    = {remy_reg[DEN_W-2:0], dvdy_reg[K-1]};

    assign cxs  = TW'(cx_reg) <<< FB;
    assign cys  = TW'(cy_reg) <<< FB;
    assign offx = TW'($signed({1'b0, qx_reg}));
    assign offy = TW'($signed({1'b0, qy_reg}));
    assign totx = cxs + (negx_reg ? -offx : offx);
    assign toty = cys + (negy_reg ? -offy : offy);
    assign resx = totx[TW-1] ? ((totx + TW'(BIAS_I)) >>> FB) : (totx >>> FB);
    assign resy = toty[TW-1] ? ((toty + TW'(BIAS_I)) >>> FB) : (toty >>> FB);

    assign moved_c = (in_data.pointer_x != last_x_reg) || (in_data.pointer_y != last_y_reg);

    assign sts.far        = far_now;
    assign sts.hit        = !far_seen_reg && ({15'b0, pp_reg} > {q_reg, 4'b0});
    assign sts.degenerate = (q_reg == '0);
    assign sts.norm_more  = (e_reg < EW'(FB)) && (nx_reg[NX_W-1:NX_W-2] == 2'b00);

    assign out_data = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= WIDTH_RESET;
            height_reg  <= HEIGHT_RESET;
            last_x_reg  <= '0;
            last_y_reg  <= '0;
            backoff_reg <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (pfp_reg_t'(cfg_index))
                    REG_WINDOW_WIDTH:  width_reg  <= cfg_data;
                    REG_WINDOW_HEIGHT: height_reg <= cfg_data;
                    default:           width_reg  <= width_reg;
                endcase
            end
            if (cmd.capture)
            begin
                if (moved_c)
                begin
                    last_x_reg  <= in_data.pointer_x;
                    last_y_reg  <= in_data.pointer_y;
                    backoff_reg <= '0;
                end
                else if (backoff_reg != 2'd3)
                begin
                    backoff_reg <= backoff_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            px_reg    <= in_data.pointer_x;
            py_reg    <= in_data.pointer_y;
            moved_reg <= moved_c;
        end
        if (cmd.geo0)
        begin
            thick_reg <= t15[24:RECIP_SHIFT];
            w20_reg   <= t20w[24:RECIP_SHIFT];
            h20_reg   <= t20h[24:RECIP_SHIFT];
        end
        if (cmd.geo1)
        begin
            padx_reg <= w20_reg + (thick_reg >> 1);
            pady_reg <= h20_reg + (thick_reg >> 1);
        end
        if (cmd.geo2)
        begin
            ew_reg <= ew_c;
            eh_reg <= eh_c;
            aw_reg <= 12'(ew_c[GEO_W-1] ? -ew_c : ew_c);
            ah_reg <= 12'(eh_c[GEO_W-1] ? -eh_c : eh_c);
        end
        if (cmd.geo3)
        begin
            cy_reg   <= half_tz(eh_reg) + spady;
            cx0_reg  <= cx0_c;
            cx1_reg  <= ew_reg + spadx + cx0_c;
            p_reg    <= 24'(aw_reg) * 24'(ah_reg);
            ball_reg <= s2[GEO_W-1] ? '0 : BALL_W'(t5[24:RECIP_SHIFT]);
        end
        if (cmd.eye_load)
        begin
            cx_reg       <= cx_sel;
            negx_reg     <= dx[DW-1];
            negy_reg     <= dy[DW-1];
            adx_reg      <= adx_c;
            ady_reg      <= ady_c;
            far_seen_reg <= far_c;
        end
        if (cmd.far_step)
        begin
            adx_reg <= adx_reg >> 1;
            ady_reg <= ady_reg >> 1;
        end
        if (cmd.mul1)
        begin
            hx_reg   <= HW'(ah_reg) * HW'(adn);
            hy_reg   <= HW'(aw_reg) * HW'(ady_n);
            numx_reg <= NUM_W'(p_reg) * NUM_W'(adn);
            numy_reg <= NUM_W'(p_reg) * NUM_W'(ady_n);
        end
        if (cmd.mul2)
        begin
            sqx_reg <= SQW'(hx_reg) * SQW'(hx_reg);
            sqy_reg <= SQW'(hy_reg) * SQW'(hy_reg);
            pp_reg  <= 48'(p_reg) * 48'(p_reg);
        end
        if (cmd.sum)
        begin
            q_reg  <= QW'(sqx_reg) + QW'(sqy_reg);
            nx_reg <= NX_W'(QW'(sqx_reg) + QW'(sqy_reg));
            e_reg  <= '0;
        end
        if (cmd.norm_step)
        begin
            nx_reg <= nx_reg << 2;
            e_reg  <= e_reg + 1'b1;
        end
        if (cmd.sqrt_load)
        begin
            src_reg <= nx_reg;
            rm_reg  <= '0;
            rt_reg  <= '0;
        end
        if (cmd.sqrt_step)
        begin
            src_reg <= src_reg << 2;
            if (sq_t >= sq_trial)
            begin
                rm_reg <= sq_t - sq_trial;
                rt_reg <= {rt_reg[30:0], 1'b1};
            end
            else
            begin
                rm_reg <= sq_t;
                rt_reg <= {rt_reg[30:0], 1'b0};
            end
        end
        if (cmd.div_load)
        begin
            den_reg  <= {rt_reg, 2'b00};
            remx_reg <= DEN_W'(shx >> K);
            remy_reg <= DEN_W'(shy >> K);
            dvdx_reg <= shx[K-1:0];
            dvdy_reg <= shy[K-1:0];
            qx_reg   <= '0;
            qy_reg   <= '0;
        end
        if (cmd.div_step)
        begin
            dvdx_reg <= dvdx_reg << 1;
            dvdy_reg <= dvdy_reg << 1;
            if (dtx >= den_reg)
            begin
                remx_reg <= dtx - den_reg;
                qx_reg   <= {qx_reg[K-2:0], 1'b1};
            end
            else
            begin
                remx_reg <= dtx;
                qx_reg   <= {qx_reg[K-2:0], 1'b0};
            end
            if (dty >= den_reg)
            begin
                remy_reg <= dty - den_reg;
                qy_reg   <= {qy_reg[K-2:0], 1'b1};
            end
            else
            begin
                remy_reg <= dty;
                qy_reg   <= {qy_reg[K-2:0], 1'b0};
            end
        end
        if (cmd.store_ptr || cmd.store_ctr || cmd.store_off)
        begin
            if (cmd.eye)
            begin
                rx_reg <= cmd.store_ptr ? px_reg : cmd.store_ctr ? COORD_BITS'(cx_reg)
                        : COORD_BITS'(resx);
                ry_reg <= cmd.store_ptr ? py_reg : cmd.store_ctr ? COORD_BITS'(cy_reg)
                        : COORD_BITS'(resy);
            end
            else
            begin
                lx_reg <= cmd.store_ptr ? px_reg : cmd.store_ctr ? COORD_BITS'(cx_reg)
                        : COORD_BITS'(resx);
                ly_reg <= cmd.store_ptr ? py_reg : cmd.store_ctr ? COORD_BITS'(cy_reg)
                        : COORD_BITS'(resy);
            end
        end
        if (cmd.out_load)
        begin
            out_reg.moved         <= moved_reg;
            out_reg.left_pupil_x  <= lx_reg;
            out_reg.left_pupil_y  <= ly_reg;
            out_reg.right_pupil_x <= rx_reg;
            out_reg.right_pupil_y <= ry_reg;
            out_reg.ball_size     <= ball_reg;
            out_reg.next_delay_ms <= delay_ms(backoff_reg);
        end
    end

endmodule
